// ----- hdl/pprc_pkg.sv -----
`timescale 1ns / 1ps

package pprc_pkg;

  // Default sizing handed to the top level.
  localparam int PATHS_DEFAULT        = 8;
  localparam int BUFFER_DEPTH_DEFAULT = 65536;

  // Fixed field widths.
  localparam int PATH_IN_W = 4;
  localparam int RANK_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int PAYLOAD_W = 32;
  localparam int BASE_W    = 16;
  localparam int COUNT_W   = 17;
  localparam int DEST_W    = 16;

  // Saturation value of a rank change count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Command codes on the cmd field.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_RESTAGE = 1'b1;

  // Classification made by the front part.
  localparam logic [1:0] KIND_SKIP = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_ELEM = 2'd2;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic [1:0]           kind;
    logic [PATH_IN_W-1:0] path;
    logic [RANK_W-1:0]    rank;
    logic [SAMPLE_W-1:0]  sample_index;
    logic [PAYLOAD_W-1:0] payload;
    logic [BASE_W-1:0]    base_offset;
    logic [COUNT_W-1:0]   count_init;
    logic                 last_element;
  } pprc_entry_t;

  // Handshake between the queue head and the back part.
  typedef struct packed {
    logic        valid;
    pprc_entry_t entry;
  } pprc_head_t;

  // One result as delivered on the output ports.
  typedef struct packed {
    logic                 write_valid;
    logic [DEST_W-1:0]    dest_index;
    logic [SAMPLE_W-1:0]  sample_out;
    logic [RANK_W-1:0]    rank_out;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [COUNT_W-1:0]   distinct_ranks;
    logic                 overflow;
    logic                 last_out;
  } pprc_result_t;

endpackage

// ----- hdl/pprc_ram.sv -----
`timescale 1ns / 1ps

module pprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port that holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/pprc_front.sv -----
`timescale 1ns / 1ps

module pprc_front #(
  parameter int PATHS = pprc_pkg::PATHS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                cmd,
  input  logic [pprc_pkg::PATH_IN_W-1:0]      path,
  input  logic [pprc_pkg::RANK_W-1:0]         rank,
  input  logic [pprc_pkg::SAMPLE_W-1:0]       sample_index,
  input  logic [pprc_pkg::PAYLOAD_W-1:0]      payload,
  input  logic [pprc_pkg::BASE_W-1:0]         base_offset,
  input  logic [pprc_pkg::COUNT_W-1:0]        count_init,
  input  logic                                last_element,
  output pprc_pkg::pprc_head_t                head,
  input  logic                                head_pop
);

  localparam int PTR_W = $clog2(pprc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pprc_pkg::QUEUE_DEPTH + 1);

  pprc_pkg::pprc_entry_t queue [pprc_pkg::QUEUE_DEPTH];
  pprc_pkg::pprc_entry_t incoming;
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      fill;
  logic                  active;
  logic                  do_push;
  logic                  do_pop;

  // Classify the request: a load or an element on an active path, or nothing.
  always_comb begin
    active = (32'(path) < PATHS);
    incoming.path         = path;
    incoming.rank         = rank;
    incoming.sample_index = sample_index;
    incoming.payload      = payload;
    incoming.base_offset  = base_offset;
    incoming.count_init   = count_init;
    incoming.last_element = last_element;
    if (!active) begin
      incoming.kind = pprc_pkg::KIND_SKIP;
    end else if (cmd == pprc_pkg::CMD_LOAD) begin
      incoming.kind = pprc_pkg::KIND_LOAD;
    end else begin
      incoming.kind = pprc_pkg::KIND_ELEM;
    end
  end

  assign full    = (fill == CNT_W'(pprc_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = head_pop && (fill != '0);

  assign head.valid = (fill != '0);
  assign head.entry = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pprc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pprc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/pprc_back.sv -----
`timescale 1ns / 1ps

module pprc_back #(
  parameter int PATHS        = pprc_pkg::PATHS_DEFAULT,
  parameter int BUFFER_DEPTH = pprc_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pprc_pkg::pprc_head_t    head,
  output logic                    head_pop,
  output logic                    empty,
  input  logic                    pop,
  output pprc_pkg::pprc_result_t  result
);

  localparam int PATH_W  = $clog2(PATHS);
  localparam int OFF_RAW = $clog2(BUFFER_DEPTH + 1);
  localparam int OFF_W   = (OFF_RAW > pprc_pkg::BASE_W + 1) ? OFF_RAW : pprc_pkg::BASE_W + 1;
  localparam int STATE_W = OFF_W + pprc_pkg::RANK_W + pprc_pkg::COUNT_W;

  // Execute stage, path state storage and result register.
  logic                          b_valid;
  pprc_pkg::pprc_entry_t         b_entry;
  logic                          b_adv;
  logic                          b_load;
  logic [PATH_W-1:0]             b_idx;
  logic [PATHS-1:0]              path_valid;
  logic                          byp_valid;
  logic [PATH_W-1:0]             byp_idx;
  logic [STATE_W-1:0]            byp_data;
  logic [STATE_W-1:0]            ram_rdata;
  logic [STATE_W-1:0]            cur;
  logic [OFF_W-1:0]              cur_off;
  logic [pprc_pkg::RANK_W-1:0]   cur_rank;
  logic [pprc_pkg::COUNT_W-1:0]  cur_cnt;
  logic [pprc_pkg::COUNT_W-1:0]  cnt_new;
  logic [OFF_W-1:0]              off_new;
  logic                          ovf;
  logic                          st_we;
  logic [STATE_W-1:0]            st_wdata;
  pprc_pkg::pprc_result_t        res;
  logic                          out_valid;
  logic                          out_ready;

  assign out_ready = !out_valid || pop;
  assign b_adv     = b_valid && out_ready;
  assign b_load    = head.valid && (!b_valid || out_ready);
  assign head_pop  = b_load;
  assign b_idx     = PATH_W'(b_entry.path);
  assign empty     = !out_valid;

  pprc_ram #(
    .WIDTH (STATE_W),
    .DEPTH (PATHS)
  ) u_state (
    .clk   (clk),
    .we    (b_adv && st_we),
    .waddr (b_idx),
    .wdata (st_wdata),
    .re    (b_load),
    .raddr (PATH_W'(head.entry.path)),
    .rdata (ram_rdata)
  );

  // Current path state: the latest state write wins over the memory,
  // and a path never loaded or touched reads as zero.
  always_comb begin
    if (byp_valid && (byp_idx == b_idx)) begin
      cur = byp_data;
    end else if (path_valid[b_idx]) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
    cur_off  = cur[STATE_W-1 -: OFF_W];
    cur_rank = cur[pprc_pkg::COUNT_W +: pprc_pkg::RANK_W];
    cur_cnt  = cur[pprc_pkg::COUNT_W-1:0];
  end

  // Update the path state and form the result.
  always_comb begin
    ovf     = (cur_off >= OFF_W'(BUFFER_DEPTH));
    off_new = ovf ? cur_off : cur_off + 1'b1;
    if ((b_entry.rank != cur_rank) && (cur_cnt != pprc_pkg::COUNT_MAX)) begin
      cnt_new = cur_cnt + 1'b1;
    end else begin
      cnt_new = cur_cnt;
    end
    res          = '0;
    res.last_out = b_entry.last_element;
    st_we        = 1'b0;
    st_wdata     = cur;
    case (b_entry.kind)
      pprc_pkg::KIND_LOAD: begin
        st_we              = 1'b1;
        st_wdata           = {OFF_W'(b_entry.base_offset), b_entry.rank, b_entry.count_init};
        res.distinct_ranks = b_entry.count_init;
      end
      pprc_pkg::KIND_ELEM: begin
        st_we              = 1'b1;
        st_wdata           = {off_new, b_entry.rank, cnt_new};
        res.distinct_ranks = cnt_new;
        res.overflow       = ovf;
        if (!ovf) begin
          res.write_valid = 1'b1;
          res.dest_index  = cur_off[pprc_pkg::DEST_W-1:0];
          res.sample_out  = b_entry.sample_index;
          res.rank_out    = b_entry.rank;
          res.payload_out = b_entry.payload;
        end
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  // Payload registers of the execute stage, bypass and result.
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_entry <= head.entry;
    end
    if (b_adv && st_we) begin
      byp_idx  <= b_idx;
      byp_data <= st_wdata;
    end
    if (b_adv) begin
      result <= res;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      out_valid  <= 1'b0;
      byp_valid  <= 1'b0;
      path_valid <= '0;
    end else begin
      if (b_load) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (b_adv && st_we) begin
        byp_valid          <= 1'b1;
        path_valid[b_idx]  <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/path_partition_rank_count_unit.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake          | Fields
// ---------+--------------------+-----------------------------------------------
// request  | push / full        | cmd path rank sample_index payload base_offset
//          |                    | count_init last_element
// result   | empty / pop        | write_valid dest_index sample_out rank_out
//          |                    | payload_out distinct_ranks overflow last_out
//
// One request is taken per cycle while the queue is not full, and one result is
// delivered per cycle while results are popped. A request passes from the queue
// into the execute stage and state memory read, then into the result register.
// Reset is synchronous; path state reads as zero after reset through per-path
// valid bits. A stalled result holds the back part; the queue keeps taking
// requests until it fills.

module path_partition_rank_count_unit #(
  parameter int PATHS        = pprc_pkg::PATHS_DEFAULT,
  parameter int BUFFER_DEPTH = pprc_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           cmd,
  input  logic [pprc_pkg::PATH_IN_W-1:0] path,
  input  logic [pprc_pkg::RANK_W-1:0]    rank,
  input  logic [pprc_pkg::SAMPLE_W-1:0]  sample_index,
  input  logic [pprc_pkg::PAYLOAD_W-1:0] payload,
  input  logic [pprc_pkg::BASE_W-1:0]    base_offset,
  input  logic [pprc_pkg::COUNT_W-1:0]   count_init,
  input  logic                           last_element,
  output logic                           empty,
  input  logic                           pop,
  output logic                           write_valid,
  output logic [pprc_pkg::DEST_W-1:0]    dest_index,
  output logic [pprc_pkg::SAMPLE_W-1:0]  sample_out,
  output logic [pprc_pkg::RANK_W-1:0]    rank_out,
  output logic [pprc_pkg::PAYLOAD_W-1:0] payload_out,
  output logic [pprc_pkg::COUNT_W-1:0]   distinct_ranks,
  output logic                           overflow,
  output logic                           last_out
);

  pprc_pkg::pprc_head_t   head;
  logic                   head_pop;
  pprc_pkg::pprc_result_t result;

  // Front part: classify requests and queue them.
  pprc_front #(
    .PATHS (PATHS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .path         (path),
    .rank         (rank),
    .sample_index (sample_index),
    .payload      (payload),
    .base_offset  (base_offset),
    .count_init   (count_init),
    .last_element (last_element),
    .head         (head),
    .head_pop     (head_pop)
  );

  // Back part: per-path state update and result register.
  pprc_back #(
    .PATHS        (PATHS),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .head_pop (head_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  assign write_valid    = result.write_valid;
  assign dest_index     = result.dest_index;
  assign sample_out     = result.sample_out;
  assign rank_out       = result.rank_out;
  assign payload_out    = result.payload_out;
  assign distinct_ranks = result.distinct_ranks;
  assign overflow       = result.overflow;
  assign last_out       = result.last_out;

endmodule
